// ===== rtl/core/ipl4_pkg.sv =====
// shared types, constants and functions of the ipv4 l4 checksum engine
package ipl4_pkg;

    localparam int unsigned Q_DEPTH_DEF = 2;

    localparam logic [3:0]  IP_VERSION   = 4'd4;
    localparam logic [3:0]  MIN_IHL      = 4'd5;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [15:0] HDR_CSUM_POS = 16'd10;
    localparam logic [15:0] TCP_CSUM_OFF = 16'd16;
    localparam logic [15:0] UDP_CSUM_OFF = 16'd6;
    localparam logic [15:0] FIRST_HDR_LEN = 16'd4;
    localparam logic [15:0] POS_MAX      = 16'hffff;
    localparam logic [15:0] SUM_MASK     = 16'hffff;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_HDR = 2'd1,
        ST_IP_ONLY = 2'd2,
        ST_TRUNC   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TCP  = 2'd1,
        KIND_UDP  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [15:0] hsum;
        logic [15:0] ssum;
        logic [7:0]  pend;
        logic [7:0]  proto;
        logic [15:0] l4len;
        logic [31:0] saddr;
        logic [31:0] daddr;
        t_status     status;
    } t_pkt_sum;

    function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        logic [16:0] f;
        t = {1'b0, s} + {1'b0, w};
        f = {1'b0, t[15:0]} + {16'd0, t[16]};
        return f[15:0];
    endfunction

endpackage

// ===== rtl/core/ipl4_if.sv =====
// byte input and result output channel interfaces
interface ipl4_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipl4_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] ip_header_checksum;
    logic [15:0] l4_checksum;
    logic [1:0]  l4_kind;
    logic [1:0]  status;

    modport source(output valid, output ip_header_checksum, output l4_checksum,
                   output l4_kind, output status, input ready);
    modport sink(input valid, input ip_header_checksum, input l4_checksum,
                 input l4_kind, input status, output ready);
endinterface

// ===== rtl/core/ipv4_l4_checksum_engine.sv =====
// top level of the ipv4 header and tcp/udp checksum engine
//
// i_byte carries an ipv4 packet one byte per item in network order, starting
// at the ip header, with last_byte high on the final byte. o_res carries one
// item per packet: header checksum, tcp/udp checksum, l4 kind and status.
// throughput: one byte per cycle, so back-to-back packets, even one-byte
// ones, stream without gaps while o_res is taken. the running sums fold each
// 16-bit word in the front end once its second byte is accepted; the
// pseudo-header sum runs in a three-stage back end behind a QUEUE_DEPTH-entry
// queue; a packet's result is valid once its sums have passed both.
// when o_res stalls, the back end holds its stages, the queue fills and then
// i_byte.ready drops; no item is lost or repeated.
// reset clears the byte position, sums, captured fields, queue and pipeline;
// the block takes bytes as soon as reset is released. state also clears
// after every last byte, so the next byte starts a new packet.
module ipv4_l4_checksum_engine
    import ipl4_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipl4_byte_if.sink   i_byte,
    ipl4_res_if.source  o_res
);

    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    t_pkt_sum rec_in;
    t_pkt_sum rec_out;

    ipl4_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (rec_in)
    );

    ipl4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_rec   (rec_out),
        .o_empty (empty)
    );

    ipl4_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_rec   (rec_out),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == ST_BAD_HDR || o_res.status == ST_TRUNC)) |->
        (o_res.ip_header_checksum == 16'd0 && o_res.l4_checksum == 16'd0 &&
         o_res.l4_kind == KIND_NONE))
        else $error("error result carries nonzero fields");

    a_kind_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.status == ST_OK) == (o_res.l4_kind != KIND_NONE)))
        else $error("l4 kind disagrees with status");

    a_udp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.l4_kind == KIND_UDP) |-> (o_res.l4_checksum != 16'd0))
        else $error("udp checksum of zero sent");

endmodule

// ===== rtl/core/ipl4_front.sv =====
// front end: header capture, running sums and per-packet status
module ipl4_front
    import ipl4_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    ipl4_byte_if.sink       i_byte,
    input  logic            i_full,
    output logic            o_push,
    output t_pkt_sum        o_rec
);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_hsum, n_hsum;
    logic [15:0] r_ssum, n_ssum;
    logic [7:0]  r_pend, n_pend;
    logic [7:0]  r_vihl, n_vihl;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_tlen, n_tlen;
    logic [31:0] r_saddr, n_saddr;
    logic [31:0] r_daddr, n_daddr;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  bz;
    logic [15:0] hlen;
    logic [15:0] off;
    logic        in_hdr;
    logic        in_pkt;
    logic        zero_b;
    logic [15:0] word;
    t_status     status;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;

    always_comb begin
        n_vihl  = (r_pos == 16'd0) ? b : r_vihl;
        n_tlen  = r_tlen;
        n_proto = r_proto;
        n_saddr = r_saddr;
        n_daddr = r_daddr;
        if (r_pos == 16'd2) begin
            n_tlen = {b, r_tlen[7:0]};
        end else if (r_pos == 16'd3) begin
            n_tlen = {r_tlen[15:8], b};
        end else if (r_pos == 16'd9) begin
            n_proto = b;
        end else if (r_pos >= 16'd12 && r_pos <= 16'd15) begin
            n_saddr = {r_saddr[23:0], b};
        end else if (r_pos >= 16'd16 && r_pos <= 16'd19) begin
            n_daddr = {r_daddr[23:0], b};
        end

        hlen   = {10'd0, n_vihl[3:0], 2'b00};
        off    = r_pos - hlen;
        in_hdr = r_pos < hlen;

        if (in_hdr) begin
            zero_b = (r_pos == HDR_CSUM_POS) || (r_pos == HDR_CSUM_POS + 16'd1);
        end else begin
            zero_b = ((n_proto == PROTO_TCP) &&
                      ((off == TCP_CSUM_OFF) || (off == TCP_CSUM_OFF + 16'd1))) ||
                     ((n_proto == PROTO_UDP) &&
                      ((off == UDP_CSUM_OFF) || (off == UDP_CSUM_OFF + 16'd1)));
        end
        bz = zero_b ? 8'd0 : b;

        in_pkt = (r_pos < FIRST_HDR_LEN) || (r_pos < n_tlen) || in_hdr;
        word   = {r_pend, bz};
        n_pend = r_pend;
        n_hsum = r_hsum;
        n_ssum = r_ssum;
        if (in_pkt) begin
            if (!r_pos[0]) begin
                n_pend = bz;
            end else if (in_hdr) begin
                n_hsum = fold_add(r_hsum, word);
            end else if (r_pos < n_tlen) begin
                n_ssum = fold_add(r_ssum, word);
            end
        end

        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 16'd1;

        if (n_vihl[7:4] != IP_VERSION || n_vihl[3:0] < MIN_IHL || n_tlen < hlen) begin
            status = ST_BAD_HDR;
        end else if (n_pos < n_tlen) begin
            status = ST_TRUNC;
        end else if (n_proto == PROTO_TCP || n_proto == PROTO_UDP) begin
            status = ST_OK;
        end else begin
            status = ST_IP_ONLY;
        end
    end

    assign o_push       = accept && i_byte.last_byte;
    assign o_rec.hsum   = n_hsum;
    assign o_rec.ssum   = n_ssum;
    assign o_rec.pend   = n_pend;
    assign o_rec.proto  = n_proto;
    assign o_rec.l4len  = n_tlen - hlen;
    assign o_rec.saddr  = n_saddr;
    assign o_rec.daddr  = n_daddr;
    assign o_rec.status = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos   <= '0;
            r_hsum  <= '0;
            r_ssum  <= '0;
            r_pend  <= '0;
            r_vihl  <= '0;
            r_proto <= '0;
            r_tlen  <= '0;
            r_saddr <= '0;
            r_daddr <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_hsum  <= n_hsum;
            r_ssum  <= n_ssum;
            r_pend  <= n_pend;
            r_vihl  <= n_vihl;
            r_proto <= n_proto;
            r_tlen  <= n_tlen;
            r_saddr <= n_saddr;
            r_daddr <= n_daddr;
        end
    end

endmodule

// ===== rtl/core/ipl4_queue.sv =====
// short fifo of per-packet sums between front and back
module ipl4_queue
    import ipl4_pkg::*;
#(
    parameter int unsigned DEPTH = Q_DEPTH_DEF
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_pkt_sum i_rec,
    output logic     o_full,
    input  logic     i_pop,
    output t_pkt_sum o_rec,
    output logic     o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_pkt_sum        r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rec   = r_mem[r_rd];
    assign n_wr    = (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
    assign n_rd    = (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/ipl4_back.sv =====
// back end: pseudo-header sum, folding and result register
module ipl4_back
    import ipl4_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_pkt_sum     i_rec,
    output logic         o_pop,
    ipl4_res_if.source   o_res
);

    logic        adv1, adv2, adv3;
    logic        r_v1, r_v2, r_v3;

    logic [16:0] r_p0, r_p1, r_p2, r_p3;
    logic [15:0] r_hc1, r_hc2;
    t_kind       r_kind1, r_kind2;
    t_status     r_st1, r_st2;
    logic [18:0] r_total;

    logic [15:0] r_hc3, r_lc3;
    t_kind       r_kind3;
    t_status     r_st3;

    t_kind       kind;
    logic [15:0] pad;
    logic [15:0] hc;
    logic [16:0] f1;
    logic [16:0] f2;
    logic [15:0] lc;

    assign adv3  = !r_v3 || o_res.ready;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    assign o_pop = !i_empty && adv1;

    always_comb begin
        if (i_rec.status != ST_OK) begin
            kind = KIND_NONE;
        end else if (i_rec.proto == PROTO_TCP) begin
            kind = KIND_TCP;
        end else begin
            kind = KIND_UDP;
        end
        pad = i_rec.l4len[0] ? {i_rec.pend, 8'd0} : 16'd0;
        hc  = (i_rec.status == ST_BAD_HDR || i_rec.status == ST_TRUNC) ?
              16'd0 : (~i_rec.hsum & SUM_MASK);
    end

    always_comb begin
        f1 = {1'b0, r_total[15:0]} + {14'd0, r_total[18:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        lc = ~f2[15:0];
        if (r_kind2 == KIND_NONE) begin
            lc = 16'd0;
        end else if (r_kind2 == KIND_UDP && lc == 16'd0) begin
            lc = SUM_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p0    <= {1'b0, i_rec.ssum} + {1'b0, pad};
            r_p1    <= {1'b0, i_rec.saddr[31:16]} + {1'b0, i_rec.saddr[15:0]};
            r_p2    <= {1'b0, i_rec.daddr[31:16]} + {1'b0, i_rec.daddr[15:0]};
            r_p3    <= {9'd0, i_rec.proto} + {1'b0, i_rec.l4len};
            r_hc1   <= hc;
            r_kind1 <= kind;
            r_st1   <= i_rec.status;
        end
        if (adv2) begin
            r_total <= {2'b00, r_p0} + {2'b00, r_p1} + {2'b00, r_p2} + {2'b00, r_p3};
            r_hc2   <= r_hc1;
            r_kind2 <= r_kind1;
            r_st2   <= r_st1;
        end
        if (adv3) begin
            r_hc3   <= r_hc2;
            r_lc3   <= lc;
            r_kind3 <= r_kind2;
            r_st3   <= r_st2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= o_pop;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_res.valid              = r_v3;
    assign o_res.ip_header_checksum = r_hc3;
    assign o_res.l4_checksum        = r_lc3;
    assign o_res.l4_kind            = r_kind3;
    assign o_res.status             = r_st3;

endmodule
